// ===== src/hex_or_decimal_text_to_integer_unit_macros.svh =====
// Assertion macros shared by the checker of the text-to-integer unit.
`ifndef HEX_OR_DECIMAL_TEXT_TO_INTEGER_UNIT_MACROS_SVH
`define HEX_OR_DECIMAL_TEXT_TO_INTEGER_UNIT_MACROS_SVH

// Checked only outside reset.
`define HODT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define HODT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hodt_pkg.sv =====
// Types, character constants and the decimal step function of the text-to-integer unit.
package hodt_pkg;

  typedef enum logic [2:0] {
    PH_FIRST      = 3'd0,
    PH_SECOND     = 3'd1,
    PH_HEX        = 3'd2,
    PH_DEC_SPACE  = 3'd3,
    PH_DEC_DIGITS = 3'd4,
    PH_FROZEN_HEX = 3'd5,
    PH_FROZEN_DEC = 3'd6
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held;
    logic [63:0] acc;
    logic        neg;
  } parse_st_t;

  localparam parse_st_t PARSE_RESET = '{phase: PH_FIRST, held: 8'h00, acc: 64'h0, neg: 1'b0};

  // decimal-side view of the state
  typedef struct packed {
    phase_t      phase;
    logic [31:0] acc;
    logic        neg;
  } dec_st_t;

  typedef struct packed {
    logic [63:0] number;
    logic        was_hex;
  } result_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // one character through the sign/space/digit parser; acc*10 as shift-add
  function automatic dec_st_t dec_feed(input dec_st_t s, input logic [7:0] c);
    dec_st_t    r;
    logic       done;
    logic [7:0] d;
    r    = s;
    done = 1'b0;
    d    = c - CH_ZERO;
    if (r.phase == PH_DEC_SPACE) begin
      priority if (c == CH_SPACE) begin
        done = 1'b1;
      end else if (c == CH_MINUS) begin
        r.neg   = 1'b1;
        r.phase = PH_DEC_DIGITS;
        done    = 1'b1;
      end else if (c == CH_PLUS) begin
        r.phase = PH_DEC_DIGITS;
        done    = 1'b1;
      end else begin
        r.phase = PH_DEC_DIGITS;
      end
    end
    if (!done && r.phase == PH_DEC_DIGITS) begin
      if (is_dec(c)) begin
        r.acc = {r.acc[28:0], 3'b000} + {r.acc[30:0], 1'b0} + {24'h0, d};
      end else begin
        r.phase = PH_FROZEN_DEC;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/hodt_step.sv =====
// Next-state and result logic for one character of the number text.
module hodt_step
  import hodt_pkg::*;
(
  input  parse_st_t  st,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  output parse_st_t  st_next,
  output result_t    res
);

  parse_st_t   n;
  dec_st_t     d;
  logic        hex_ok;
  logic [3:0]  hex_dig;
  logic [31:0] mag;
  logic [31:0] sval;

  always_comb begin
    hex_ok  = 1'b1;
    hex_dig = 4'h0;
    priority if (is_dec(text_char)) begin
      hex_dig = text_char[3:0];
    end else if (text_char >= CH_UC_A && text_char <= CH_UC_F) begin
      hex_dig = 4'(text_char - CH_UC_A + 8'd10);
    end else if (text_char >= CH_LC_A && text_char <= CH_LC_F) begin
      hex_dig = 4'(text_char - CH_LC_A + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    n = st;
    d = '{phase: PH_DEC_SPACE, acc: 32'h0, neg: 1'b0};
    unique case (st.phase)
      PH_FIRST: begin
        n.held = text_char;
        n.acc  = 64'h0;
        n.neg  = 1'b0;
        priority if (text_char == CH_NUL) begin
          n.phase = PH_FROZEN_DEC;
        end else if (end_of_text) begin
          // single-character text is decimal
          d       = dec_feed(d, text_char);
          n.phase = d.phase;
          n.acc   = {32'h0, d.acc};
          n.neg   = d.neg;
        end else begin
          n.phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (text_char == CH_LC_X || text_char == CH_UC_X) begin
          n.phase = PH_HEX;
        end else begin
          // replay the held first char, then this one
          d = dec_feed('{phase: PH_DEC_SPACE, acc: st.acc[31:0], neg: st.neg}, st.held);
          if (text_char == CH_NUL) begin
            d.phase = PH_FROZEN_DEC;
          end else begin
            d = dec_feed(d, text_char);
          end
          n.phase = d.phase;
          n.acc   = {32'h0, d.acc};
          n.neg   = d.neg;
        end
      end
      PH_HEX: begin
        if (hex_ok) begin
          n.acc = {st.acc[59:0], hex_dig};
        end else begin
          n.phase = PH_FROZEN_HEX;
        end
      end
      PH_DEC_SPACE, PH_DEC_DIGITS: begin
        d       = dec_feed('{phase: st.phase, acc: st.acc[31:0], neg: st.neg}, text_char);
        n.phase = d.phase;
        n.acc   = {32'h0, d.acc};
        n.neg   = d.neg;
      end
      default: begin
        n = st;
      end
    endcase
  end

  always_comb begin
    mag  = n.acc[31:0];
    sval = n.neg ? (32'h0 - mag) : mag;
    if (n.phase == PH_HEX || n.phase == PH_FROZEN_HEX) begin
      res.number  = n.acc;
      res.was_hex = 1'b1;
    end else begin
      res.number  = {{32{sval[31]}}, sval};
      res.was_hex = 1'b0;
    end
    st_next = end_of_text ? PARSE_RESET : n;
  end

endmodule

// ===== src/hodt_out_reg.sv =====
// Result register on the master side; holds a word while the receiver stalls.
module hodt_out_reg
  import hodt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic        m_tuser
);

  logic    valid;
  result_t data;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = data.number;
  assign m_tuser  = data.was_hex;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= res;
    end
  end

endmodule

// ===== src/hex_or_decimal_text_to_integer_unit.sv =====
// Top level of the streaming hex/decimal text-to-integer unit.
//
// Slave side takes one ASCII character per word (tdata[7:0]); tlast marks the
// final character of a text. Master side gives one 64-bit number per text,
// with tuser high when read as hexadecimal (an 'x' or 'X' as second character).
// Decimal values wrap at 32 bits and come out sign-extended to 64 bits.
//
// A result passes the input register, where its tlast word lands, and then
// the result register, which the parse step loads from it once it is free.
// Throughput: one character per cycle, unless a tlast word waits for the
// result register; the parse step (a shift-add or a hex-digit shift on the
// accumulator) is combinational.
//
// Reset clears the parser state, the input valid and the result valid.
// When the receiver stalls, the result is held; characters that produce no
// result keep flowing, and a tlast word waits in the input register until
// the result register frees, which then stalls the slave side.
module hex_or_decimal_text_to_integer_unit
  import hodt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] text_char
  input  logic        s_tlast,    // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // [63:0] number
  output logic        m_tuser     // [0] was_hex
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  parse_st_t st;
  parse_st_t st_next;
  result_t   res;
  logic      out_free;
  logic      proc;

  // a word moves on unless it ends a text and the result slot is full
  assign proc     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (proc) begin
      st <= st_next;
    end
  end

  hodt_step u_step (
    .st          (st),
    .text_char   (in_char),
    .end_of_text (in_last),
    .st_next     (st_next),
    .res         (res)
  );

  hodt_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (proc && in_last),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== src/hodt_checker.sv =====
// Port-level checker for the text-to-integer unit, bound to the top level.
`include "hex_or_decimal_text_to_integer_unit_macros.svh"

module hodt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // stalled result word holds
  `HODT_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

  // reset empties the result register
  `HODT_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // with no result pending, the slave side never stalls
  `HODT_ASSERT_ALWAYS(a_ready_empty, clk, !m_tvalid |-> s_tready, "slave stalled with empty result slot")

  // decimal results are sign-extended 32-bit values
  `HODT_ASSERT(a_dec_sext, clk, rst, m_tvalid && !m_tuser |-> m_tdata[63:32] == {32{m_tdata[31]}}, "decimal result not sign-extended")

endmodule

bind hex_or_decimal_text_to_integer_unit hodt_checker u_hodt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/hex_or_decimal_text_to_integer_unit_tb.sv =====
// Self-checking testbench for the streaming hex/decimal text-to-integer unit.
module hex_or_decimal_text_to_integer_unit_tb;
  import hodt_pkg::*;

  // Give up after this many cycles in which no word moves on either side.
  // The slowest correct gap is a sender gap plus a receiver stall plus the
  // path of a result through the input and result registers.
  localparam int STALL_LIMIT = 500;
  localparam int REPORT_MAX  = 10;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] text_char
  logic        s_tlast  = 1'b0;   // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [63:0] number
  logic        m_tuser;           // [0] was_hex

  hex_or_decimal_text_to_integer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Parser mirror: tracks the unit's state word by word and queues the
  // number each text should produce.
  // ---------------------------------------------------------------------
  phase_t      prs_phase = PH_FIRST;
  logic [7:0]  prs_first = 8'h00;
  logic [63:0] prs_acc   = 64'h0;
  logic        prs_neg   = 1'b0;
  result_t     pending_numbers[$];

  int error_count    = 0;
  int chars_sent     = 0;
  int texts_sent     = 0;
  int hex_results    = 0;
  int dec_results    = 0;
  int idle_cycles    = 0;

  // Sign/space/digit handling; digits wrap at 32 bits.
  function automatic void dec_char(input logic [7:0] c);
    logic [31:0] v;
    v = prs_acc[31:0];
    if (prs_phase == PH_DEC_SPACE) begin
      if (c == CH_SPACE) return;
      if (c == CH_MINUS) begin
        prs_neg   = 1'b1;
        prs_phase = PH_DEC_DIGITS;
        return;
      end
      if (c == CH_PLUS) begin
        prs_phase = PH_DEC_DIGITS;
        return;
      end
      prs_phase = PH_DEC_DIGITS;
    end
    if (prs_phase == PH_DEC_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v       = v * 32'd10 + {24'h0, c - CH_ZERO};
        prs_acc = {32'h0, v};
      end else begin
        prs_phase = PH_FROZEN_DEC;
      end
    end
  endfunction

  // Hex digits of either case shift in modulo 2^64; anything else freezes.
  function automatic void hex_char(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = c - CH_UC_A + 8'd10;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = c - CH_LC_A + 8'd10;
    end else begin
      prs_phase = PH_FROZEN_HEX;
      return;
    end
    prs_acc = (prs_acc << 4) + {60'h0, d[3:0]};
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic last);
    logic [31:0] v;
    result_t     res;
    case (prs_phase)
      PH_FIRST: begin
        prs_first = c;
        prs_acc   = 64'h0;
        prs_neg   = 1'b0;
        if (c == CH_NUL) begin
          prs_phase = PH_FROZEN_DEC;
        end else if (last) begin
          // a one-character text is always decimal
          prs_phase = PH_DEC_SPACE;
          dec_char(c);
        end else begin
          prs_phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (c == CH_LC_X || c == CH_UC_X) begin
          prs_phase = PH_HEX;
        end else begin
          // replay the held first character, then this one
          prs_phase = PH_DEC_SPACE;
          dec_char(prs_first);
          if (c == CH_NUL) prs_phase = PH_FROZEN_DEC;
          else dec_char(c);
        end
      end
      PH_HEX: hex_char(c);
      PH_DEC_SPACE, PH_DEC_DIGITS: dec_char(c);
      default: ;
    endcase
    if (last) begin
      if (prs_phase == PH_HEX || prs_phase == PH_FROZEN_HEX) begin
        res.number  = prs_acc;
        res.was_hex = 1'b1;
      end else begin
        v = prs_acc[31:0];
        if (prs_neg) v = 32'h0 - v;
        res.number  = {{32{v[31]}}, v};
        res.was_hex = 1'b0;
      end
      pending_numbers.push_back(res);
      prs_phase = PH_FIRST;
      prs_first = 8'h00;
      prs_acc   = 64'h0;
      prs_neg   = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Both handshakes are sampled at the rising edge; inputs move at the
  // falling edge, so the values seen here are the ones the unit latched.
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_numbers.size() == 0) begin
          note_mismatch("unexpected word", 64'h0, m_tdata);
        end else begin
          want = pending_numbers.pop_front();
          if (m_tdata !== want.number) note_mismatch("number", want.number, m_tdata);
          if (m_tuser !== want.was_hex) note_mismatch("was_hex", {63'h0, want.was_hex},
                                                      {63'h0, m_tuser});
          if (want.was_hex) hex_results++;
          else dec_results++;
        end
      end
      if (s_tvalid && s_tready) parse_char(s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_numbers.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: ready follows a repeating low/high window whose shape is
  // re-drawn every time the window wraps.
  // ---------------------------------------------------------------------
  bit stalls_on = 1'b1;
  int rx_pos    = 0;
  int rx_period = 4;
  int rx_stall  = 0;

  always @(negedge clk) begin
    rx_pos++;
    if (rx_pos >= rx_period) begin
      rx_pos    = 0;
      rx_period = $urandom_range(2, 16);
      rx_stall  = $urandom_range(0, rx_period - 1);
    end
    m_tready <= !stalls_on || (rx_pos >= rx_stall);
  end

  // ---------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------
  bit         gaps_on    = 1'b1;
  int         burst_left = 0;
  logic [7:0] text_q[$];

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (gaps_on && burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_char(text_q[i], i == n - 1);
    text_q.delete();
    texts_sent++;
  endtask

  // Hold the sender off until every queued number has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_numbers.size() != 0);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_ZERO + k[7:0];
    if (k < 16) return CH_LC_A + k[7:0] - 8'd10;
    return CH_UC_A + k[7:0] - 8'd16;
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Trailing garbage after a valid body, NUL often among it.
  function automatic void push_junk();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      text_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : rand_byte());
  endfunction

  function automatic void build_hex_text();
    int n;
    if ($urandom_range(0, 3) != 0) text_q.push_back(CH_ZERO);
    else text_q.push_back(8'($urandom_range(1, 255)));
    text_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
    // mostly short bodies, some long enough to wrap past 64 bits
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) text_q.push_back(rand_hex_char());
    if ($urandom_range(0, 4) == 0) push_junk();
  endfunction

  function automatic void build_dec_text();
    int n;
    int sign;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < n; i++) text_q.push_back(CH_SPACE);
    sign = $urandom_range(0, 2);
    if (sign == 1) text_q.push_back(CH_PLUS);
    if (sign == 2) text_q.push_back(CH_MINUS);
    // some digit runs long enough to wrap the 32-bit accumulator
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
    for (int i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0 || text_q.size() == 0) push_junk();
  endfunction

  function automatic void build_noise_text();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) text_q.push_back(rand_byte());
    if (n > 1 && $urandom_range(0, 3) == 0) text_q[1] = CH_LC_X;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Corner texts: bare prefix, one-character texts, NUL first and second,
  // lone sign, leading space with minus, frozen hex, any first character
  // before 'x', the all-ones byte, decimal wrap.
  task automatic test_special_texts();
    push_str("0x");          send_text();
    push_str("A");           send_text();
    text_q.push_back(CH_NUL); send_text();
    push_str("9"); text_q.push_back(CH_NUL); send_text();
    push_str("-");           send_text();
    push_str(" -12");        send_text();
    push_str("0XfG");        send_text();
    push_str("zx");          send_text();
    text_q.push_back(8'hFF); send_text();
    push_str("5000000000");  send_text();
    push_str("+7");          send_text();
    drain_results();
  endtask

  task automatic test_hex_texts(input int budget);
    int stop_at;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      build_hex_text();
      send_text();
    end
  endtask

  task automatic test_decimal_texts(input int budget);
    int stop_at;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      build_dec_text();
      send_text();
    end
  endtask

  task automatic test_noise_texts(input int budget);
    int stop_at;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      build_noise_text();
      send_text();
    end
  endtask

  // Mixed kinds with idling switched on and off, and the sender paused
  // now and then until the output side has caught up.
  task automatic test_mixed_texts(input int budget);
    int stop_at;
    int kind;
    stop_at = chars_sent + budget;
    while (chars_sent < stop_at) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      kind      = $urandom_range(0, 9);
      if (kind < 4) build_hex_text();
      else if (kind < 8) build_dec_text();
      else build_noise_text();
      send_text();
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_special_texts();
    test_hex_texts(450);
    test_decimal_texts(450);
    // back-to-back with no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_noise_texts(250);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_mixed_texts(450);

    drain_results();
    repeat (8) @(negedge clk);

    $display("covered %0d texts over %0d characters: %0d hex and %0d decimal numbers",
             texts_sent, chars_sent, hex_results, dec_results);
    $display("with prefixes, signs, NULs, wraparound and noise under gaps and stalls");
    if (error_count == 0 && pending_numbers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d numbers never seen", error_count,
               pending_numbers.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hodt_pkg.sv
src/hodt_step.sv
src/hodt_out_reg.sv
src/hex_or_decimal_text_to_integer_unit.sv
src/hodt_checker.sv
dv/hex_or_decimal_text_to_integer_unit_tb.sv
